### hw/rtl/xrsd_pkg.sv
// Shared types and constants of the cross-reference stream row decoder.
`timescale 1ns / 1ps
`default_nettype none

package xrsd_pkg;

    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 24;
    localparam int OBJ_W         = 24;
    localparam int OUT_FIELD_W   = 32;
    localparam int POS_W         = 5;
    localparam int ROW_POSITIONS = 32;

    // Entry type that marks an object stored inside an object stream
    localparam logic [OUT_FIELD_W-1:0] TYPE_COMPRESSED = 32'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DATA_COLUMNS   = 3'd0,
        REG_WIDTH_TYPE     = 3'd1,
        REG_WIDTH_OFFSET   = 3'd2,
        REG_WIDTH_GEN      = 3'd3,
        REG_PREDICTOR_MODE = 3'd4,
        REG_FIRST_OBJECT   = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        FLD_TYPE,
        FLD_SECOND,
        FLD_THIRD,
        FLD_NONE
    } field_sel_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_begin;
        logic       stream_end;
    } in_t;

    typedef struct packed {
        logic [OUT_FIELD_W-1:0] entry_type;
        logic [OUT_FIELD_W-1:0] second_field;
        logic [OUT_FIELD_W-1:0] third_field;
        logic [OBJ_W-1:0]       object_id;
        logic [OUT_FIELD_W-1:0] start_byte;
        logic [OUT_FIELD_W-1:0] container_object;
        logic                   size_error;
    } out_t;

    typedef struct packed {
        logic [4:0]       data_columns;
        logic [2:0]       width_type;
        logic [2:0]       width_offset;
        logic [2:0]       width_gen;
        logic [1:0]       predictor_mode;
        logic [OBJ_W-1:0] first_object;
    } cfg_t;

    // Control handed from the position tracker to the field stage
    typedef struct packed {
        logic [7:0]       data_byte;
        logic             stream_begin;
        logic             has_data;
        field_sel_t       field_sel;
        logic             add_en;
        logic             fwd;
        logic             row_done;
        logic             size_err;
        logic [OBJ_W-1:0] object_id;
    } item_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/xrsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module xrsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/xrsd_cfg.sv
// Configuration register file of the row decoder.
`timescale 1ns / 1ps
`default_nettype none

module xrsd_cfg (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [xrsd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [xrsd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output xrsd_pkg::cfg_t                        cfg
);

    xrsd_pkg::cfg_t cfg_reg;

    // Write the addressed register; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.data_columns   <= 5'd4;
            cfg_reg.width_type     <= 3'd1;
            cfg_reg.width_offset   <= 3'd2;
            cfg_reg.width_gen      <= 3'd1;
            cfg_reg.predictor_mode <= 2'd0;
            cfg_reg.first_object   <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                xrsd_pkg::REG_DATA_COLUMNS:   cfg_reg.data_columns   <= cfg_wdata[4:0];
                xrsd_pkg::REG_WIDTH_TYPE:     cfg_reg.width_type     <= cfg_wdata[2:0];
                xrsd_pkg::REG_WIDTH_OFFSET:   cfg_reg.width_offset   <= cfg_wdata[2:0];
                xrsd_pkg::REG_WIDTH_GEN:      cfg_reg.width_gen      <= cfg_wdata[2:0];
                xrsd_pkg::REG_PREDICTOR_MODE: cfg_reg.predictor_mode <= cfg_wdata[1:0];
                xrsd_pkg::REG_FIRST_OBJECT:
                    cfg_reg.first_object <= cfg_wdata[xrsd_pkg::OBJ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### hw/rtl/xrsd_track.sv
// Row position tracker: column and row counters, line buffer read and valid flags.
`timescale 1ns / 1ps
`default_nettype none

module xrsd_track #(
    parameter int MAX_ROW_BYTES = 32,
    parameter int SLOT_W        = $clog2(MAX_ROW_BYTES)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire xrsd_pkg::cfg_t        cfg,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire xrsd_pkg::in_t         s_data,
    input  wire logic                  p1_adv,
    output logic                       rd_en,
    output logic [SLOT_W-1:0]          rd_slot,
    output logic                       wr_en,
    output logic [SLOT_W-1:0]          wr_slot,
    output logic                       item_valid,
    output xrsd_pkg::item_ctl_t        item_ctl
);

    localparam int POS_W = xrsd_pkg::POS_W;
    localparam int OBJ_W = xrsd_pkg::OBJ_W;

    logic [POS_W-1:0]          pos_reg, pos_next;
    logic [OBJ_W-1:0]          rc_reg, rc_next;
    logic                      frf_reg, frf_next;
    logic [MAX_ROW_BYTES-1:0]  valid_reg;
    logic                      p1_valid_reg;
    xrsd_pkg::item_ctl_t       item_reg;
    logic [SLOT_W-1:0]         slot_reg;

    logic [SLOT_W-1:0]         slot_tbl [xrsd_pkg::ROW_POSITIONS];

    logic                      accept;
    logic                      filter, up;
    logic [POS_W-1:0]          cols;
    logic [POS_W:0]            row_len;
    logic [POS_W-1:0]          pos, d;
    logic                      frf;
    logic [OBJ_W-1:0]          rc;
    logic [POS_W-1:0]          lim_type, lim_second, lim_third;
    logic [SLOT_W-1:0]         slot;
    logic                      has_data, fwd, row_done;
    logic [OBJ_W:0]            obj_sum;
    xrsd_pkg::field_sel_t      sel;

    // Column to line buffer slot, folded at elaboration
    for (genvar i = 0; i < xrsd_pkg::ROW_POSITIONS; i++) begin : g_slot
        assign slot_tbl[i] = SLOT_W'(i % MAX_ROW_BYTES);
    end

    assign s_ready = !p1_valid_reg || p1_adv;
    assign accept  = s_valid && s_ready;

    // Decode row geometry and the position of the incoming word
    always_comb begin
        filter     = cfg.predictor_mode != 2'd0;
        up         = cfg.predictor_mode[1];
        cols       = (cfg.data_columns == '0) ? POS_W'(1) : cfg.data_columns;
        row_len    = {1'b0, cols} + (POS_W + 1)'(filter);
        pos        = s_data.stream_begin ? '0 : pos_reg;
        frf        = s_data.stream_begin || frf_reg;
        rc         = s_data.stream_begin ? '0 : rc_reg;
        has_data   = !(filter && pos == '0);
        d          = pos - POS_W'(filter);
        lim_type   = POS_W'(cfg.width_type);
        lim_second = lim_type + POS_W'(cfg.width_offset);
        lim_third  = lim_second + POS_W'(cfg.width_gen);
        if (d < lim_type) begin
            sel = xrsd_pkg::FLD_TYPE;
        end else if (d < lim_second) begin
            sel = xrsd_pkg::FLD_SECOND;
        end else if (d < lim_third) begin
            sel = xrsd_pkg::FLD_THIRD;
        end else begin
            sel = xrsd_pkg::FLD_NONE;
        end
        slot     = slot_tbl[pos];
        row_done = ({1'b0, pos} + (POS_W + 1)'(1)) >= row_len;
        obj_sum  = {1'b0, cfg.first_object} + {1'b0, rc};
    end

    // Forward the word that stage 1 writes in this cycle to the same slot
    assign wr_en   = p1_valid_reg && item_reg.has_data && p1_adv;
    assign wr_slot = slot_reg;
    assign fwd     = wr_en && (slot_reg == slot);

    assign rd_en   = accept;
    assign rd_slot = slot;

    // Advance column, row count and first-row flag
    always_comb begin
        pos_next = pos_reg;
        rc_next  = rc_reg;
        frf_next = frf_reg;
        if (accept) begin
            frf_next = frf;
            rc_next  = rc;
            if (row_done) begin
                pos_next = '0;
                rc_next  = (rc == '1) ? rc : rc + OBJ_W'(1);
                frf_next = 1'b0;
            end else if (s_data.stream_end) begin
                pos_next = '0;
            end else begin
                pos_next = pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            rc_reg       <= '0;
            frf_reg      <= 1'b1;
            valid_reg    <= '0;
            p1_valid_reg <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            rc_reg  <= rc_next;
            frf_reg <= frf_next;
            // Stream start clears the line buffer after the older word's write
            if (wr_en) begin
                valid_reg[slot_reg] <= 1'b1;
            end
            if (accept && s_data.stream_begin) begin
                valid_reg <= '0;
            end
            if (accept) begin
                p1_valid_reg <= 1'b1;
            end else if (p1_adv) begin
                p1_valid_reg <= 1'b0;
            end
        end
    end

    // Load the stage 1 control word
    always_ff @(posedge aclk) begin
        if (accept) begin
            slot_reg               <= slot;
            item_reg.data_byte     <= s_data.data_byte;
            item_reg.stream_begin  <= s_data.stream_begin;
            item_reg.has_data      <= has_data;
            item_reg.field_sel     <= sel;
            item_reg.add_en        <= up && !frf && (valid_reg[slot] || fwd);
            item_reg.fwd           <= fwd;
            item_reg.row_done      <= row_done;
            item_reg.size_err      <= s_data.stream_end && !row_done;
            item_reg.object_id     <= obj_sum[OBJ_W] ? '1 : obj_sum[OBJ_W-1:0];
        end
    end

    assign item_valid = p1_valid_reg;
    assign item_ctl   = item_reg;

    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.stream_begin |=> valid_reg == '0)
        else $error("line buffer flags not cleared after stream start");

    a_rc_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        !(accept && s_data.stream_begin) |=> rc_reg >= $past(rc_reg))
        else $error("row count fell without stream start");

endmodule

`default_nettype wire

### hw/rtl/xrsd_field.sv
// Field stage: Up add, line buffer write-back, field accumulators and output register.
`timescale 1ns / 1ps
`default_nettype none

module xrsd_field #(
    parameter int FIELD_BYTES = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 item_valid,
    input  wire xrsd_pkg::item_ctl_t  item_ctl,
    input  wire logic [7:0]           rd_data,
    output logic                      p1_adv,
    output logic [7:0]                wr_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output xrsd_pkg::out_t            m_data
);

    localparam int ACC_W = 8 * FIELD_BYTES;
    localparam int OUT_W = xrsd_pkg::OUT_FIELD_W;

    logic [ACC_W-1:0]   type_acc_reg, second_acc_reg, third_acc_reg;
    logic [7:0]         last_wr_reg;
    logic               out_valid_reg;
    xrsd_pkg::out_t     out_reg;
    xrsd_pkg::out_t     out_next;

    logic [7:0]         prev, v;
    logic [ACC_W-1:0]   base_t, base_s, base_g;
    logic [ACC_W-1:0]   new_t, new_s, new_g;
    logic [OUT_W-1:0]   t, s, g;
    logic               emit, advance, push;

    // Add the byte of the previous row, forwarded when just written
    always_comb begin
        prev    = item_ctl.fwd ? last_wr_reg : rd_data;
        v       = item_ctl.data_byte + (item_ctl.add_en ? prev : 8'd0);
        wr_data = v;
    end

    // Shift the decoded byte into the selected field
    always_comb begin
        base_t = item_ctl.stream_begin ? '0 : type_acc_reg;
        base_s = item_ctl.stream_begin ? '0 : second_acc_reg;
        base_g = item_ctl.stream_begin ? '0 : third_acc_reg;
        push   = item_ctl.has_data;
        new_t  = base_t;
        new_s  = base_s;
        new_g  = base_g;
        if (push) begin
            case (item_ctl.field_sel)
                xrsd_pkg::FLD_TYPE:   new_t = ACC_W'({base_t, v});
                xrsd_pkg::FLD_SECOND: new_s = ACC_W'({base_s, v});
                xrsd_pkg::FLD_THIRD:  new_g = ACC_W'({base_g, v});
                default: begin
                end
            endcase
        end
        t = OUT_W'(new_t);
        s = OUT_W'(new_s);
        g = OUT_W'(new_g);
    end

    // Build the result word; a size error carries nothing but its flag
    always_comb begin
        out_next = '0;
        if (item_ctl.size_err) begin
            out_next.size_error = 1'b1;
        end else begin
            out_next.entry_type       = t;
            out_next.second_field     = s;
            out_next.third_field      = g;
            out_next.object_id        = item_ctl.object_id;
            out_next.start_byte       = (t != xrsd_pkg::TYPE_COMPRESSED) ? s : '0;
            out_next.container_object = (t == xrsd_pkg::TYPE_COMPRESSED) ? s : '0;
        end
    end

    // Stall only behind an occupied output register
    assign emit    = item_ctl.row_done || item_ctl.size_err;
    assign p1_adv  = !(item_valid && emit && out_valid_reg && !m_ready);
    assign advance = item_valid && p1_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            type_acc_reg   <= '0;
            second_acc_reg <= '0;
            third_acc_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (advance) begin
                if (emit) begin
                    type_acc_reg   <= '0;
                    second_acc_reg <= '0;
                    third_acc_reg  <= '0;
                end else begin
                    type_acc_reg   <= new_t;
                    second_acc_reg <= new_s;
                    third_acc_reg  <= new_g;
                end
            end
            if (advance && emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the last written byte and load the result word
    always_ff @(posedge aclk) begin
        if (advance && push) begin
            last_wr_reg <= v;
        end
        if (advance && emit) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.size_error |->
            (m_data.entry_type == '0 && m_data.second_field == '0 &&
             m_data.third_field == '0 && m_data.object_id == '0))
        else $error("size error word carries field data");

    a_split: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.start_byte == '0 || m_data.container_object == '0))
        else $error("start byte and container object both set");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !p1_adv |-> (m_valid && item_valid && emit))
        else $error("stage 1 stalled without a waiting result");

endmodule

`default_nettype wire

### hw/rtl/xref_stream_row_decoder.sv
// Top level of the cross-reference stream row decoder.
//
// Usage: stream decompressed cross-reference bytes into s_ (valid/ready), one byte per
// word, with stream_begin on the first byte and stream_end on the last. Each completed
// row yields one entry word on m_ (valid/ready); a stream that ends inside a row yields
// one word with size_error set and all other fields zero.
// Configuration goes through cfg_we/cfg_index/cfg_wdata, one register per write, and
// takes effect for the next byte; write it only while no byte is in flight.
// Throughput: one byte per cycle while not stalled. The line buffer is a RAM with one read and one
// write per byte; the read is issued when the byte is taken, the write when it leaves
// the stage 1 register, with forwarding when two bytes in a row hit the same slot.
// The entry word of a row reaches m_ through the stage 1 register and the result register.
// Stall: the result register holds while m_ready is low; one more byte is still taken
// into the field stage, and more after it as long as they complete no row.
// Reset: registers return to their defaults (4, 1, 2, 1, 0, 0), counters clear and
// every line buffer slot reads as zero through per-slot valid flags; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module xref_stream_row_decoder #(
    parameter int MAX_ROW_BYTES = 32,
    parameter int FIELD_BYTES   = 4
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [xrsd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [xrsd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire xrsd_pkg::in_t                    s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output xrsd_pkg::out_t                        m_data
);

    localparam int SLOT_W = $clog2(MAX_ROW_BYTES);

    xrsd_pkg::cfg_t       cfg;
    xrsd_pkg::item_ctl_t  item_ctl;
    logic                 item_valid;
    logic                 p1_adv;
    logic                 rd_en, wr_en;
    logic [SLOT_W-1:0]    rd_slot, wr_slot;
    logic [7:0]           rd_data, wr_data;

    xrsd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    xrsd_track #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .SLOT_W        (SLOT_W)
    ) u_track (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .p1_adv     (p1_adv),
        .rd_en      (rd_en),
        .rd_slot    (rd_slot),
        .wr_en      (wr_en),
        .wr_slot    (wr_slot),
        .item_valid (item_valid),
        .item_ctl   (item_ctl)
    );

    xrsd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ROW_BYTES)
    ) u_line_buf (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_slot),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_slot),
        .rdata (rd_data)
    );

    xrsd_field #(
        .FIELD_BYTES (FIELD_BYTES)
    ) u_field (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_ctl   (item_ctl),
        .rd_data    (rd_data),
        .p1_adv     (p1_adv),
        .wr_data    (wr_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire

### verif/xrsd_entry_checker.sv
// Entry checker for the cross-reference stream row decoder: predicts and compares entry words.
`timescale 1ns / 1ps

module xrsd_entry_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [xrsd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [xrsd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  xrsd_pkg::in_t                        s_data,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  xrsd_pkg::out_t                       m_data,
    output int                                   error_count,
    output int                                   expected_left
);

    localparam int OBJ_W       = xrsd_pkg::OBJ_W;
    localparam int POS_W       = xrsd_pkg::POS_W;
    localparam int OUT_FIELD_W = xrsd_pkg::OUT_FIELD_W;
    localparam logic [OBJ_W-1:0] OBJ_LAST = '1;
    localparam int MAX_REPORTS = 50;

    // Shadow of the decoder registers and row state
    xrsd_pkg::cfg_t         cfg;
    logic [7:0]             line_buf [xrsd_pkg::ROW_POSITIONS];
    logic [POS_W-1:0]       col_pos;
    logic [OBJ_W-1:0]       rows_done;
    logic [OUT_FIELD_W-1:0] acc_type;
    logic [OUT_FIELD_W-1:0] acc_second;
    logic [OUT_FIELD_W-1:0] acc_third;
    logic                   first_row;

    // Newest prediction at the front, oldest at the back
    xrsd_pkg::out_t entry_queue [$];

    function automatic void clear_row();
        col_pos    = '0;
        acc_type   = '0;
        acc_second = '0;
        acc_third  = '0;
    endfunction

    // Advance the row state by one stream byte; return 1 when an entry word results
    function automatic bit decode_byte(input xrsd_pkg::in_t w, output xrsd_pkg::out_t entry);
        int unsigned filt;
        int unsigned row_len;
        int unsigned pos;
        int unsigned slot;
        int unsigned d;
        int unsigned wt;
        int unsigned wo;
        int unsigned wg;
        int unsigned obj_sum;
        logic [7:0]  add;
        logic [7:0]  v;
        bit          up;

        entry   = '0;
        filt    = (cfg.predictor_mode != 2'd0) ? 1 : 0;
        up      = cfg.predictor_mode[1];
        row_len = ((cfg.data_columns == 5'd0) ? 1 : cfg.data_columns) + filt;
        wt      = cfg.width_type;
        wo      = cfg.width_offset;
        wg      = cfg.width_gen;
        pos     = col_pos;

        // Stream start wipes the row history before the byte is taken
        if (w.stream_begin) begin
            line_buf  = '{default: 8'h00};
            clear_row();
            rows_done = '0;
            first_row = 1'b1;
            pos       = 0;
        end

        // Drop the filter byte; otherwise apply Up and shift into the field it belongs to
        if (!(filt == 1 && pos == 0)) begin
            slot = pos % xrsd_pkg::ROW_POSITIONS;
            d    = pos - filt;
            add  = (up && !first_row) ? line_buf[slot] : 8'h00;
            v    = w.data_byte + add;
            line_buf[slot] = v;
            if (d < wt) begin
                acc_type = {acc_type[OUT_FIELD_W-9:0], v};
            end else if (d < wt + wo) begin
                acc_second = {acc_second[OUT_FIELD_W-9:0], v};
            end else if (d < wt + wo + wg) begin
                acc_third = {acc_third[OUT_FIELD_W-9:0], v};
            end
        end

        // Row complete: emit the entry, numbered with saturation
        if (pos + 1 >= row_len) begin
            obj_sum                = cfg.first_object + rows_done;
            entry.entry_type       = acc_type;
            entry.second_field     = acc_second;
            entry.third_field      = acc_third;
            entry.object_id        = (obj_sum > OBJ_LAST) ? OBJ_LAST : OBJ_W'(obj_sum);
            entry.start_byte       = (acc_type != xrsd_pkg::TYPE_COMPRESSED) ? acc_second : '0;
            entry.container_object = (acc_type == xrsd_pkg::TYPE_COMPRESSED) ? acc_second : '0;
            if (rows_done != OBJ_LAST) rows_done++;
            first_row = 1'b0;
            clear_row();
            return 1'b1;
        end

        col_pos = POS_W'(pos + 1);

        // Stream ended inside a row: flag it and discard the partial row
        if (w.stream_end) begin
            entry            = '0;
            entry.size_error = 1'b1;
            clear_row();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic check_field(input string label, input logic [OUT_FIELD_W-1:0] want,
                               input logic [OUT_FIELD_W-1:0] got);
        if (got !== want) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %h, got %h", $time, label, want, got);
        end
    endtask

    // Watch both channels and the register port at every rising edge
    always @(posedge aclk) begin
        xrsd_pkg::out_t want;
        xrsd_pkg::out_t fresh;

        if (!aresetn) begin
            cfg         = '{data_columns: 5'd4, width_type: 3'd1, width_offset: 3'd2,
                            width_gen: 3'd1, predictor_mode: 2'd0, first_object: '0};
            line_buf    = '{default: 8'h00};
            clear_row();
            rows_done   = '0;
            first_row   = 1'b1;
            error_count = 0;
            entry_queue.delete();
        end else begin
            // Compare the accepted entry word against the oldest prediction
            if (m_valid && m_ready) begin
                if (entry_queue.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t ns: unexpected entry word, expected none, got %h",
                                 $time, m_data);
                end else begin
                    want = entry_queue.pop_back();
                    check_field("entry_type", want.entry_type, m_data.entry_type);
                    check_field("second_field", want.second_field, m_data.second_field);
                    check_field("third_field", want.third_field, m_data.third_field);
                    check_field("object_id", want.object_id, m_data.object_id);
                    check_field("start_byte", want.start_byte, m_data.start_byte);
                    check_field("container_object", want.container_object,
                                m_data.container_object);
                    check_field("size_error", want.size_error, m_data.size_error);
                end
            end

            // Track register writes
            if (cfg_we) begin
                case (cfg_index)
                    xrsd_pkg::REG_DATA_COLUMNS:   cfg.data_columns   = cfg_wdata[4:0];
                    xrsd_pkg::REG_WIDTH_TYPE:     cfg.width_type     = cfg_wdata[2:0];
                    xrsd_pkg::REG_WIDTH_OFFSET:   cfg.width_offset   = cfg_wdata[2:0];
                    xrsd_pkg::REG_WIDTH_GEN:      cfg.width_gen      = cfg_wdata[2:0];
                    xrsd_pkg::REG_PREDICTOR_MODE: cfg.predictor_mode = cfg_wdata[1:0];
                    xrsd_pkg::REG_FIRST_OBJECT:   cfg.first_object   = cfg_wdata[OBJ_W-1:0];
                    default: ;
                endcase
            end

            // Predict the entry word, if any, for each accepted stream byte
            if (s_valid && s_ready) begin
                if (decode_byte(s_data, fresh)) entry_queue.push_front(fresh);
            end
        end
        expected_left = entry_queue.size();
    end

endmodule

### verif/tb_xref_stream_row_decoder.sv
// Top of the cross-reference stream row decoder testbench: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_xref_stream_row_decoder;

    localparam int CFG_IDX_W     = xrsd_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W    = xrsd_pkg::CFG_DATA_W;
    localparam int OBJ_W         = xrsd_pkg::OBJ_W;
    localparam int CLK_HALF      = 4;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 60;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd6;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    xrsd_pkg::in_t         s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    xrsd_pkg::out_t        m_data;

    int error_count;
    int expected_left;
    int cycle_count = 0;
    int sent_count  = 0;
    int burst_left  = 0;
    int stall_style = 0;
    int stall_left  = 0;

    // Row geometry as currently programmed, for shaping streams
    logic [4:0] cur_cols = 5'd4;
    logic [1:0] cur_mode = 2'd0;

    xref_stream_row_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    xrsd_entry_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .error_count   (error_count),
        .expected_left (expected_left)
    );

    always begin
        aclk = 1'b0;
        #(CLK_HALF);
        aclk = 1'b1;
        #(CLK_HALF);
    end

    // Bound the run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("xref_stream_row_decoder test failed");
            $finish;
        end
    end

    // Receiver: pick one of four stall styles at random and hold it for a random span
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_style <= $urandom_range(0, 3);
            stall_left  <= $urandom_range(20, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_style)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= (stall_left % 4 == 0);
            default: m_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    function automatic int row_bytes();
        return ((cur_cols == 5'd0) ? 1 : int'(cur_cols)) + ((cur_mode != 2'd0) ? 1 : 0);
    endfunction

    function automatic xrsd_pkg::in_t make_word(input logic [7:0] b, input logic st,
                                                input logic en);
        xrsd_pkg::in_t w;
        w.data_byte    = b;
        w.stream_begin = st;
        w.stream_end   = en;
        return w;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h02;
            default: return 8'($urandom);
        endcase
    endfunction

    // Present one word and hold it until taken; insert a gap at the end of a burst
    task automatic send_word(input xrsd_pkg::in_t w);
        int gap;
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(0, 12);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Send whole rows plus a tail of a row, optionally marking start and end
    task automatic send_stream(input int rows, input int tail, input bit lead_start,
                               input bit close);
        int total;
        total = rows * row_bytes() + tail;
        for (int i = 0; i < total; i++)
            send_word(make_word(pick_byte(), lead_start && i == 0, close && i == total - 1));
    endtask

    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++)
            send_word(make_word(pick_byte(), $urandom_range(0, 9) == 0,
                                $urandom_range(0, 5) == 0));
    endtask

    // Hold off until every predicted entry has come out and the pipeline is empty
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (expected_left != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One write per cycle; the caller drops the write enable
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // Program all registers; junk in the unused upper bits must be ignored
    task automatic apply_settings(input logic [4:0] cols, input logic [2:0] wt,
                                  input logic [2:0] wo, input logic [2:0] wg,
                                  input logic [1:0] mode, input logic [OBJ_W-1:0] first);
        write_reg(xrsd_pkg::REG_DATA_COLUMNS,   {19'($urandom), cols});
        write_reg(xrsd_pkg::REG_WIDTH_TYPE,     {21'($urandom), wt});
        write_reg(xrsd_pkg::REG_WIDTH_OFFSET,   {21'($urandom), wo});
        write_reg(xrsd_pkg::REG_WIDTH_GEN,      {21'($urandom), wg});
        write_reg(xrsd_pkg::REG_PREDICTOR_MODE, {22'($urandom), mode});
        write_reg(xrsd_pkg::REG_FIRST_OBJECT,   first);
        cfg_we   <= 1'b0;
        cur_cols  = cols;
        cur_mode  = mode;
    endtask

    initial begin
        int  phase_base;
        int  pick;
        int  tail;
        bit  carry;

        carry = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: compressed-type row, all-ones row with end on its last byte
        send_word(make_word(8'h02, 1'b1, 1'b0));
        send_word(make_word(8'hAB, 1'b0, 1'b0));
        send_word(make_word(8'hCD, 1'b0, 1'b0));
        send_word(make_word(8'h07, 1'b0, 1'b0));
        send_word(make_word(8'hFF, 1'b0, 1'b0));
        send_word(make_word(8'hFF, 1'b0, 1'b0));
        send_word(make_word(8'hFF, 1'b0, 1'b0));
        send_word(make_word(8'hFF, 1'b0, 1'b1));
        // Stream ends two bytes into a row
        send_word(make_word(8'h00, 1'b0, 1'b0));
        send_word(make_word(8'h00, 1'b0, 1'b1));
        // Stream start in the middle of a row restarts everything
        send_word(make_word(8'h5A, 1'b0, 1'b0));
        send_word(make_word(8'h01, 1'b1, 1'b0));
        send_word(make_word(8'h00, 1'b0, 1'b0));
        send_word(make_word(8'h10, 1'b0, 1'b0));
        send_word(make_word(8'hFF, 1'b0, 1'b0));
        drain_results();

        // Writes to an unmapped index change nothing
        write_reg(REG_UNUSED, 24'($urandom));
        cfg_we <= 1'b0;
        @(posedge aclk);

        // Up predictor, zero-width type field, byte wrap and object number saturation
        apply_settings(5'd2, 3'd0, 3'd1, 3'd1, 2'd2, 24'hFFFFFE);
        send_word(make_word(8'h00, 1'b1, 1'b0));
        send_word(make_word(8'h02, 1'b0, 1'b0));
        send_word(make_word(8'hFF, 1'b0, 1'b0));
        send_word(make_word(8'h01, 1'b0, 1'b0));
        send_word(make_word(8'h01, 1'b0, 1'b0));
        send_word(make_word(8'h01, 1'b0, 1'b0));
        send_word(make_word(8'h04, 1'b0, 1'b0));
        send_word(make_word(8'hFF, 1'b0, 1'b0));
        send_word(make_word(8'hFF, 1'b0, 1'b1));
        drain_results();

        // Random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: apply_settings(5'd31, 3'd4, 3'd4, 3'd4, 2'd2, 24'h000000);
                1: apply_settings(5'd1, 3'd1, 3'd0, 3'd0, 2'd1, 24'hFFFFFF);
                2: apply_settings(5'd0, 3'd0, 3'd7, 3'd7, 2'd3, 24'hFFFFFA);
                3: apply_settings(5'd6, 3'd7, 3'd0, 3'd7, 2'd0, 24'h000100);
                4: apply_settings(5'd3, 3'd1, 3'd2, 3'd0, 2'd2, 24'($urandom));
                default: apply_settings(
                    ($urandom_range(0, 2) == 0) ? 5'($urandom_range(0, 31))
                                                : 5'($urandom_range(1, 8)),
                    3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                    3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                    ($urandom_range(0, 1) == 0) ? 24'($urandom)
                                                : 24'hFFFFFF - 24'($urandom_range(0, 8)));
            endcase

            // Finish a row cut under the old row length
            if (carry) send_stream(1, 0, 1'b0, 1'b1);

            phase_base = sent_count;
            while (sent_count - phase_base < PHASE_ITEMS) begin
                pick = $urandom_range(0, 19);
                tail = (row_bytes() > 1) ? $urandom_range(1, row_bytes() - 1) : 0;
                if (pick < 12) begin
                    send_stream($urandom_range(1, (row_bytes() > 12) ? 2 : 5), 0, 1'b1, 1'b1);
                end else if (pick < 14) begin
                    send_stream($urandom_range(0, 2), tail, 1'b1, 1'b1);
                end else if (pick == 14) begin
                    send_stream($urandom_range(1, 2), 0, 1'b0, 1'($urandom_range(0, 1)));
                end else if (pick == 15) begin
                    send_stream(0, tail, 1'b1, 1'b0);
                end else if (pick == 16) begin
                    send_noise($urandom_range(1, 6));
                end else if (pick == 17) begin
                    drain_results();
                end else begin
                    send_stream($urandom_range(1, 3), 0, 1'b1, 1'b0);
                end
            end

            // Sometimes leave a row open across the register change
            carry = ($urandom_range(0, 1) == 1) && (row_bytes() > 1);
            if (carry) send_stream(0, $urandom_range(1, row_bytes() - 1), 1'b0, 1'b0);
            drain_results();
        end

        drain_results();
        if (error_count == 0) begin
            $display("xref_stream_row_decoder test passed");
        end else begin
            $display("xref_stream_row_decoder test failed");
        end
        $finish;
    end

endmodule

### xref_stream_row_decoder.f
hw/rtl/xrsd_pkg.sv
hw/rtl/xrsd_ram.sv
hw/rtl/xrsd_cfg.sv
hw/rtl/xrsd_track.sv
hw/rtl/xrsd_field.sv
hw/rtl/xref_stream_row_decoder.sv
verif/xrsd_entry_checker.sv
verif/tb_xref_stream_row_decoder.sv
